// ----- src/mbrs_pkg.sv -----
// Shared types, constants and the CRC-16 step function for the Modbus RTU register slave.
// Used by mbrs_ctrl, mbrs_dp and modbus_rtu_register_slave_core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mbrs_pkg;

   localparam int NUM_REGISTERS   = 10;
   localparam int MAX_FRAME_BYTES = 256;
   localparam int HEAD_LEN        = 8;

   localparam int IDX_W   = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
   localparam int CNT_W   = $clog2(NUM_REGISTERS + 1);
   localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);

   localparam logic [7:0]  FN_READ    = 8'h03;
   localparam logic [7:0]  FN_WRITE   = 8'h06;
   localparam logic [15:0] REG0_RESET = 16'd250;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  ID_RESET   = 8'd1;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_READ,
      KIND_WRITE
   } frame_kind_type;

   typedef enum logic [2:0] {
      SRC_ID,
      SRC_FUNC,
      SRC_BCNT,
      SRC_REG_HI,
      SRC_REG_LO,
      SRC_CRC_LO,
      SRC_CRC_HI,
      SRC_HEAD
   } byte_src_type;

   typedef struct packed {
      logic         take;
      logic         check;
      logic         load;
      byte_src_type src;
      logic         last;
      logic [2:0]   head_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic             frame_done;
      frame_kind_type   kind;
      logic [CNT_W-1:0] word_count;
      logic             out_free;
   } dp_status_type;

   // One byte through the reflected CRC-16 (polynomial 0xA001).
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- src/mbrs_dp.sv -----
// Datapath of the Modbus RTU register slave: request CRC, head bytes, register file,
// response CRC and the output register. Depends on mbrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbrs_dp (
   input  wire                    clock,
   input  wire                    reset,
   input  mbrs_pkg::dp_cmd_type   cmd,
   output mbrs_pkg::dp_status_type status,
   input  wire  [7:0]             req_tdata,
   input  wire                    req_tlast,
   input  wire                    csr_valid,
   input  wire  [7:0]             csr_data,
   input  wire                    rsp_tready,
   output logic                   rsp_tvalid,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);

   localparam logic [mbrs_pkg::COUNT_W-1:0] LAST_POS =
      mbrs_pkg::COUNT_W'(mbrs_pkg::MAX_FRAME_BYTES - 1);
   localparam logic [mbrs_pkg::COUNT_W-1:0] HEAD_MIN = mbrs_pkg::COUNT_W'(mbrs_pkg::HEAD_LEN);

   logic [7:0]                     slave_id_ff;
   logic [15:0]                    crc_rx_ff, crc_rx_in;
   logic [mbrs_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [7:0]                     head_ff [mbrs_pkg::HEAD_LEN];
   logic [15:0]                    reg_file_ff [mbrs_pkg::NUM_REGISTERS];
   logic [mbrs_pkg::IDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [15:0]                    crc_tx_ff, crc_tx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [15:0] addr, cnt, rd_word;
   logic [16:0] span;
   logic        len_ok, id_ok, crc_ok;
   logic [7:0]  tx_byte;
   mbrs_pkg::frame_kind_type kind;

   assign addr    = {head_ff[2], head_ff[3]};
   assign cnt     = {head_ff[4], head_ff[5]};
   assign span    = {1'b0, addr} + {1'b0, cnt};
   assign len_ok  = (count_ff >= HEAD_MIN);
   assign id_ok   = (head_ff[0] == slave_id_ff);
   assign crc_ok  = (crc_rx_ff == 16'h0000);
   assign rd_word = reg_file_ff[rd_ptr_ff];

   always_comb begin
      kind = mbrs_pkg::KIND_NONE;
      if (len_ok && id_ok && crc_ok) begin
         if (head_ff[1] == mbrs_pkg::FN_READ) begin
            if (span <= 17'(mbrs_pkg::NUM_REGISTERS)) begin
               kind = mbrs_pkg::KIND_READ;
            end
         end else if (head_ff[1] == mbrs_pkg::FN_WRITE) begin
            if (addr < 16'(mbrs_pkg::NUM_REGISTERS)) begin
               kind = mbrs_pkg::KIND_WRITE;
            end
         end
      end
   end

   always_comb begin
      case (cmd.src)
         mbrs_pkg::SRC_ID:     tx_byte = slave_id_ff;
         mbrs_pkg::SRC_FUNC:   tx_byte = mbrs_pkg::FN_READ;
         mbrs_pkg::SRC_BCNT:   tx_byte = {head_ff[5][6:0], 1'b0};
         mbrs_pkg::SRC_REG_HI: tx_byte = rd_word[15:8];
         mbrs_pkg::SRC_REG_LO: tx_byte = rd_word[7:0];
         mbrs_pkg::SRC_CRC_LO: tx_byte = crc_tx_ff[7:0];
         mbrs_pkg::SRC_CRC_HI: tx_byte = crc_tx_ff[15:8];
         mbrs_pkg::SRC_HEAD:   tx_byte = head_ff[cmd.head_idx];
         default:              tx_byte = slave_id_ff;
      endcase
   end

   always_comb begin
      crc_rx_in = crc_rx_ff;
      count_in  = count_ff;
      if (cmd.check) begin
         crc_rx_in = mbrs_pkg::CRC_INIT;
         count_in  = '0;
      end else if (cmd.take) begin
         crc_rx_in = mbrs_pkg::crc_feed(crc_rx_ff, req_tdata);
         count_in  = count_ff + 1'b1;
      end

      rd_ptr_in = rd_ptr_ff;
      crc_tx_in = crc_tx_ff;
      if (cmd.check) begin
         rd_ptr_in = head_ff[3][mbrs_pkg::IDX_W-1:0];
         crc_tx_in = mbrs_pkg::CRC_INIT;
      end else if (cmd.load) begin
         if (cmd.src == mbrs_pkg::SRC_REG_LO) begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
         if (cmd.src != mbrs_pkg::SRC_CRC_LO && cmd.src != mbrs_pkg::SRC_CRC_HI) begin
            crc_tx_in = mbrs_pkg::crc_feed(crc_tx_ff, tx_byte);
         end
      end

      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = tx_byte;
         rsp_last_in  = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_ff  <= mbrs_pkg::ID_RESET;
         crc_rx_ff    <= mbrs_pkg::CRC_INIT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < mbrs_pkg::NUM_REGISTERS; i++) begin
            reg_file_ff[i] <= (i == 0) ? mbrs_pkg::REG0_RESET : 16'h0000;
         end
      end else begin
         if (csr_valid) begin
            slave_id_ff <= csr_data;
         end
         crc_rx_ff    <= crc_rx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.check && kind == mbrs_pkg::KIND_WRITE) begin
            reg_file_ff[head_ff[3][mbrs_pkg::IDX_W-1:0]] <= cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && count_ff < HEAD_MIN) begin
         head_ff[count_ff[2:0]] <= req_tdata;
      end
      rd_ptr_ff   <= rd_ptr_in;
      crc_tx_ff   <= crc_tx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.frame_done = cmd.take && (req_tlast || count_ff == LAST_POS);
   assign status.kind       = kind;
   assign status.word_count = head_ff[5][mbrs_pkg::CNT_W-1:0];
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response byte loaded over an untaken byte");

   a_no_take_in_check: assert property (@(posedge clock) disable iff (reset)
      cmd.check |-> !cmd.take)
      else $error("request byte taken during frame check");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> (count_ff <= LAST_POS))
      else $error("frame byte count ran past the frame limit");

endmodule

`default_nettype wire

// ----- src/mbrs_ctrl.sv -----
// Controller of the Modbus RTU register slave: collects frames, checks them and
// sequences the response bytes. Depends on mbrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbrs_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  mbrs_pkg::dp_status_type status,
   output mbrs_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_CHECK,
      ST_HEAD,
      ST_DATA,
      ST_CRC,
      ST_ECHO
   } state_type;

   state_type                  state_ff, state_in;
   logic [2:0]                 pos_ff, pos_in;
   logic                       low_ff, low_in;
   logic [mbrs_pkg::CNT_W-1:0] words_ff, words_in;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      low_in       = low_ff;
      words_in     = words_ff;
      cmd.take     = 1'b0;
      cmd.check    = 1'b0;
      cmd.load     = 1'b0;
      cmd.src      = mbrs_pkg::SRC_ID;
      cmd.last     = 1'b0;
      cmd.head_idx = pos_ff;

      unique case (state_ff)
         ST_COLLECT: begin
            cmd.take = req_tvalid;
            if (status.frame_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            pos_in    = '0;
            low_in    = 1'b0;
            words_in  = status.word_count;
            unique case (status.kind)
               mbrs_pkg::KIND_READ:  state_in = ST_HEAD;
               mbrs_pkg::KIND_WRITE: state_in = ST_ECHO;
               default:              state_in = ST_COLLECT;
            endcase
         end
         ST_HEAD: begin
            unique case (pos_ff)
               3'd0:    cmd.src = mbrs_pkg::SRC_ID;
               3'd1:    cmd.src = mbrs_pkg::SRC_FUNC;
               default: cmd.src = mbrs_pkg::SRC_BCNT;
            endcase
            if (status.out_free) begin
               cmd.load = 1'b1;
               pos_in   = pos_ff + 1'b1;
               if (pos_ff == 3'd2) begin
                  pos_in   = '0;
                  state_in = (words_ff == '0) ? ST_CRC : ST_DATA;
               end
            end
         end
         ST_DATA: begin
            cmd.src = low_ff ? mbrs_pkg::SRC_REG_LO : mbrs_pkg::SRC_REG_HI;
            if (status.out_free) begin
               cmd.load = 1'b1;
               low_in   = !low_ff;
               if (low_ff) begin
                  words_in = words_ff - 1'b1;
                  if (words_ff == mbrs_pkg::CNT_W'(1)) begin
                     state_in = ST_CRC;
                  end
               end
            end
         end
         ST_CRC: begin
            cmd.src  = pos_ff[0] ? mbrs_pkg::SRC_CRC_HI : mbrs_pkg::SRC_CRC_LO;
            cmd.last = pos_ff[0];
            if (status.out_free) begin
               cmd.load = 1'b1;
               pos_in   = pos_ff + 1'b1;
               if (pos_ff[0]) begin
                  state_in = ST_COLLECT;
               end
            end
         end
         ST_ECHO: begin
            cmd.src  = mbrs_pkg::SRC_HEAD;
            cmd.last = (pos_ff == 3'(mbrs_pkg::HEAD_LEN - 1));
            if (status.out_free) begin
               cmd.load = 1'b1;
               pos_in   = pos_ff + 1'b1;
               if (pos_ff == 3'(mbrs_pkg::HEAD_LEN - 1)) begin
                  state_in = ST_COLLECT;
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   assign req_tready = (state_ff == ST_COLLECT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         pos_ff   <= '0;
         low_ff   <= 1'b0;
         words_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         low_ff   <= low_in;
         words_ff <= words_in;
      end
   end

   a_check_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |=> (state_ff != ST_CHECK))
      else $error("frame check held for more than one cycle");

   a_check_after_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COLLECT && status.frame_done) |=> (state_ff == ST_CHECK))
      else $error("frame end did not start a frame check");

   a_data_has_words: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA) |-> (words_ff != '0))
      else $error("register data sent with no words left");

endmodule

`default_nettype wire

// ----- src/modbus_rtu_register_slave_core.sv -----
// After the frame's last byte the controller passes through a check state, and then loads
// the first response byte into the output register as soon as that register is free.
// Throughput: one request byte per cycle while collecting; response bytes go out one per
// cycle while rsp_tready is high, from 0 bytes up to 25 (read) or 8 (write echo).
// No request byte is taken from frame end until the last response byte is loaded.
// Reset is synchronous: slave id 1, register 0 holds 250, all others 0, empty frame.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the Modbus RTU slave with a holding-register file.
// Instantiates mbrs_ctrl and mbrs_dp; uses mbrs_pkg.
module modbus_rtu_register_slave_core (
   input  wire        clock,
   input  wire        reset,
   // Request byte stream.
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] rx_byte
   input  wire        req_tlast,   // frame_end
   // Response byte stream.
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] tx_byte
   output logic       rsp_tlast,   // tx_last
   // Slave id register write channel.
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire  [7:0] csr_data     // [7:0] slave_id
);

   mbrs_pkg::dp_cmd_type    cmd;
   mbrs_pkg::dp_status_type status;

   // The slave id register can be written in any cycle, so every write transfer is taken
   // at once. Writes are only expected while no frame is in flight.
   assign csr_ready = 1'b1;

   // The controller walks through collect, check and the response phases. While it
   // collects, each request transfer updates the running CRC and the head bytes in the
   // datapath. A frame ends on tlast or when its 256th byte arrives.
   mbrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the frame state, the register file and a one-deep output register.
   // The output register lets the controller finish a response and take the next request
   // while the final response byte still waits for its transfer.
   mbrs_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the Modbus RTU holding-register slave core.
// Drives request frames, predicts every response byte and checks it; depends on mbrs_pkg.
`timescale 1ns / 1ps

module tb_top;

   // Function codes that the slave does not serve, used to hit the silent path.
   localparam logic [7:0] FN_MULTI_WRITE = 8'h10;
   localparam logic [7:0] FN_ALL_ONES    = 8'hFF;
   // Slave ids used in the directed part besides the reset id.
   localparam logic [7:0] ID_MIN   = 8'h00;
   localparam logic [7:0] ID_MAX   = 8'hFF;
   localparam logic [7:0] ID_OTHER = 8'h02;

   localparam int RANDOM_BYTES  = 20;     // well-formed request bytes in the random part
   localparam int SETTLE_CYCLES = 8;      // check cycle plus output register, with margin
   localparam int DRAIN_LIMIT   = 5000;   // cycles the end waits for outstanding bytes
   localparam int CYCLE_LIMIT   = 400000; // hard stop for a hung run

   // How a directed row gets its expected response: from the predictor, typed as silence,
   // or typed as an echo of the first eight request bytes.
   typedef enum logic [1:0] {
      EXP_MODEL,
      EXP_NONE,
      EXP_ECHO
   } exp_kind_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } resp_byte_type;

   typedef struct {
      logic       set_id;    // write the slave id register before this frame
      logic [7:0] new_id;
      logic [7:0] dst;       // byte zero of the request
      logic [7:0] func;
      logic [15:0] addr;
      logic [15:0] word;     // register count for reads, value for writes
      int          len;      // total frame length in bytes, CRC included
      logic        crc_ok;
      logic        end_mark; // tlast on the final byte
      exp_kind_type kind;
   } dir_row_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data   = 8'h00;

   // Mirror of the slave: register file, id and the frame being collected.
   logic [7:0]  mirror_id;
   logic [15:0] mirror_crc;
   int          mirror_len;
   logic [7:0]  mirror_head [mbrs_pkg::HEAD_LEN];
   logic [15:0] mirror_regs [mbrs_pkg::NUM_REGISTERS];

   resp_byte_type answer_bytes [$]; // response of the frame that just closed
   resp_byte_type resp_due [$];     // response bytes still to come out of the block

   logic typed_expect = 1'b0;    // current frame carries a typed expectation
   logic tx_burst     = 1'b0;    // sender runs without gaps for this frame
   logic rsp_burst    = 1'b0;    // receiver runs without stalls for now
   int   mismatch_count = 0;
   int   cycle_count    = 0;
   int   resp_index     = 0;

   // Directed frames. Silent and echo rows are typed; reads go through the predictor.
   dir_row_type dir_rows [19] = '{
      // Register 0 right after reset, then the full file (the longest response).
      '{1'b0, ID_MIN, mbrs_pkg::ID_RESET, mbrs_pkg::FN_READ, 16'd0, 16'd1, 8, 1'b1, 1'b1,
        EXP_MODEL},
      '{1'b0, ID_MIN, mbrs_pkg::ID_RESET, mbrs_pkg::FN_READ, 16'd0, 16'd10, 8, 1'b1, 1'b1,
        EXP_MODEL},
      // Writes at the top and bottom of the file with extreme values.
      '{1'b0, ID_MIN, mbrs_pkg::ID_RESET, mbrs_pkg::FN_WRITE, 16'd9, 16'hFFFF, 8, 1'b1, 1'b1,
        EXP_ECHO},
      '{1'b0, ID_MIN, mbrs_pkg::ID_RESET, mbrs_pkg::FN_WRITE, 16'd0, 16'h0000, 8, 1'b1, 1'b1,
        EXP_ECHO},
      // A write one past the file is dropped and stays silent.
      '{1'b0, ID_MIN, mbrs_pkg::ID_RESET, mbrs_pkg::FN_WRITE, 16'd10, 16'h1234, 8, 1'b1, 1'b1,
        EXP_NONE},
      // A read of zero registers right at the end of the file still answers.
      '{1'b0, ID_MIN, mbrs_pkg::ID_RESET, mbrs_pkg::FN_READ, 16'd10, 16'd0, 8, 1'b1, 1'b1,
        EXP_MODEL},
      // Reads that run past the file, one of them only without wrap of the sum.
      '{1'b0, ID_MIN, mbrs_pkg::ID_RESET, mbrs_pkg::FN_READ, 16'd5, 16'd6, 8, 1'b1, 1'b1,
        EXP_NONE},
      '{1'b0, ID_MIN, mbrs_pkg::ID_RESET, mbrs_pkg::FN_READ, 16'hFFFF, 16'hFFFF, 8, 1'b1, 1'b1,
        EXP_NONE},
      // Corrupted CRC, foreign id, unsupported function.
      '{1'b0, ID_MIN, mbrs_pkg::ID_RESET, mbrs_pkg::FN_READ, 16'd0, 16'd10, 8, 1'b0, 1'b1,
        EXP_NONE},
      '{1'b0, ID_MIN, ID_OTHER, mbrs_pkg::FN_READ, 16'd0, 16'd1, 8, 1'b1, 1'b1, EXP_NONE},
      '{1'b0, ID_MIN, mbrs_pkg::ID_RESET, FN_MULTI_WRITE, 16'd0, 16'd1, 8, 1'b1, 1'b1,
        EXP_NONE},
      // Frames shorter than eight bytes, even with a good CRC.
      '{1'b0, ID_MIN, mbrs_pkg::ID_RESET, mbrs_pkg::FN_READ, 16'd0, 16'd1, 7, 1'b1, 1'b1,
        EXP_NONE},
      '{1'b0, ID_MIN, ID_MAX, mbrs_pkg::FN_READ, 16'd0, 16'd1, 1, 1'b1, 1'b1, EXP_NONE},
      // Highest id, with filler bytes between the header and the CRC.
      '{1'b1, ID_MAX, ID_MAX, mbrs_pkg::FN_WRITE, 16'd1, 16'h00FF, 12, 1'b1, 1'b1, EXP_ECHO},
      '{1'b0, ID_MAX, ID_MAX, mbrs_pkg::FN_READ, 16'd0, 16'd10, 8, 1'b1, 1'b1, EXP_MODEL},
      // Lowest id.
      '{1'b1, ID_MIN, ID_MIN, mbrs_pkg::FN_WRITE, 16'd5, 16'h8001, 8, 1'b1, 1'b1, EXP_ECHO},
      '{1'b0, ID_MIN, ID_MIN, mbrs_pkg::FN_READ, 16'd0, 16'd3, 8, 1'b1, 1'b1, EXP_MODEL},
      '{1'b0, ID_MIN, ID_MIN, FN_ALL_ONES, 16'd0, 16'd1, 8, 1'b1, 1'b1, EXP_NONE},
      // Back to the reset id.
      '{1'b1, mbrs_pkg::ID_RESET, mbrs_pkg::ID_RESET, mbrs_pkg::FN_READ, 16'd0, 16'd10, 9,
        1'b1, 1'b1, EXP_MODEL}
   };

   modbus_rtu_register_slave_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cycle counter with a hard stop, so that a hung handshake cannot stall the run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", CYCLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   // One byte through the reflected CRC-16, least significant bit first.
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) begin
         c = c[0] ? ((c >> 1) ^ mbrs_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Appends one non-final response byte and folds it into the response CRC.
   function automatic void answer_push(input logic [7:0] b, inout logic [15:0] crc);
      answer_bytes.push_back({b, 1'b0});
      crc = crc16_feed(crc, b);
   endfunction

   // Decides the response of a closed frame from the mirrored header and register file.
   function automatic void answer_frame();
      int unsigned word_addr;
      int unsigned reg_cnt;
      logic [15:0] crc;
      logic [15:0] val;
      if (mirror_len < mbrs_pkg::HEAD_LEN || mirror_head[0] != mirror_id ||
          mirror_crc != 16'h0000) begin
         return;
      end
      word_addr = 32'({mirror_head[2], mirror_head[3]});
      reg_cnt   = 32'({mirror_head[4], mirror_head[5]});
      if (mirror_head[1] == mbrs_pkg::FN_READ) begin
         // The sum is taken in 32 bits, so large address and count never wrap.
         if (word_addr + reg_cnt > mbrs_pkg::NUM_REGISTERS) begin
            return;
         end
         crc = mbrs_pkg::CRC_INIT;
         answer_push(mirror_id, crc);
         answer_push(mbrs_pkg::FN_READ, crc);
         answer_push(8'(reg_cnt * 2), crc);
         for (int i = 0; i < reg_cnt; i++) begin
            val = mirror_regs[word_addr + i];
            answer_push(val[15:8], crc);
            answer_push(val[7:0], crc);
         end
         answer_bytes.push_back({crc[7:0], 1'b0});
         answer_bytes.push_back({crc[15:8], 1'b1});
      end else if (mirror_head[1] == mbrs_pkg::FN_WRITE) begin
         if (word_addr >= mbrs_pkg::NUM_REGISTERS) begin
            return;
         end
         mirror_regs[word_addr] = reg_cnt[15:0];
         for (int i = 0; i < mbrs_pkg::HEAD_LEN; i++) begin
            answer_bytes.push_back({mirror_head[i], i == mbrs_pkg::HEAD_LEN - 1});
         end
      end
   endfunction

   // Mirrors one accepted request byte; a frame closes on tlast or at the length limit.
   function automatic void accept_byte(input logic [7:0] b, input logic last);
      if (mirror_len < mbrs_pkg::HEAD_LEN) begin
         mirror_head[mirror_len] = b;
      end
      mirror_crc = crc16_feed(mirror_crc, b);
      mirror_len++;
      if (last || mirror_len >= mbrs_pkg::MAX_FRAME_BYTES) begin
         answer_frame();
         mirror_crc = mbrs_pkg::CRC_INIT;
         mirror_len = 0;
      end
   endfunction

   // Offers one request byte after a random gap and waits for its transfer.
   // The valid is lowered only when a gap follows, so it never toggles within one step.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      accept_byte(b, last);
      if (!typed_expect) begin
         foreach (answer_bytes[i]) resp_due.push_back(answer_bytes[i]);
      end
      answer_bytes.delete();
   endtask

   // Builds a request: header, filler up to the length, then the CRC low byte first.
   // Frames under three bytes carry no CRC; a bad CRC flips one bit of the final byte.
   task automatic send_frame(input logic [7:0] dst, input logic [7:0] func,
                             input logic [15:0] addr, input logic [15:0] word,
                             input int len, input logic crc_ok, input logic end_mark,
                             input exp_kind_type kind);
      logic [7:0]  hdr [6];
      logic [7:0]  body [$];
      logic [15:0] crc;
      int          nbody;
      hdr = '{dst, func, addr[15:8], addr[7:0], word[15:8], word[7:0]};
      nbody = (len >= 3) ? len - 2 : len;
      for (int i = 0; i < nbody; i++) begin
         body.push_back((i < 6) ? hdr[i] : 8'($urandom));
      end
      if (len >= 3) begin
         crc = mbrs_pkg::CRC_INIT;
         foreach (body[i]) crc = crc16_feed(crc, body[i]);
         body.push_back(crc[7:0]);
         body.push_back(crc[15:8]);
      end
      if (!crc_ok) begin
         body[len - 1] = body[len - 1] ^ 8'(1 << $urandom_range(0, 7));
      end
      // Silent rows expect nothing; echo rows expect the first eight request bytes back.
      typed_expect = (kind != EXP_MODEL);
      if (kind == EXP_ECHO) begin
         for (int i = 0; i < mbrs_pkg::HEAD_LEN; i++) begin
            resp_due.push_back({body[i], i == mbrs_pkg::HEAD_LEN - 1});
         end
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         send_byte(body[i], (i == len - 1) ? end_mark : 1'b0);
      end
      typed_expect = 1'b0;
   endtask

   // Holds the sender until every predicted byte is out, then lets the block settle,
   // since a silent frame may still be in its check cycle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (resp_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The id register is only written while the block is idle.
   task automatic set_slave_id(input logic [7:0] id);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= id;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mirror_id = id;
   endtask

   // Response sink: a random stall before each byte, with bursts of no stalls.
   // Each byte that transfers is compared field by field with the oldest expectation.
   initial begin : resp_sink
      int            stall;
      resp_byte_type due;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            rsp_burst = !rsp_burst;
         end
         stall = rsp_burst ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (resp_due.size() == 0) begin
            report_mismatch($sformatf("unexpected response byte %02h tlast %0b",
                                      rsp_tdata, rsp_tlast));
         end else begin
            due = resp_due.pop_front();
            if (rsp_tdata !== due.data) begin
               report_mismatch($sformatf("byte %0d tdata %02h, expected %02h",
                                         resp_index, rsp_tdata, due.data));
            end
            if (rsp_tlast !== due.last) begin
               report_mismatch($sformatf("byte %0d tlast %0b, expected %0b",
                                         resp_index, rsp_tlast, due.last));
            end
         end
         resp_index++;
      end
   end

   initial begin : stimulus
      int          rand_bytes;
      int          frame_no;
      int          pick;
      int          sel;
      int          waited;
      int          len;
      logic [7:0]  dst;
      logic [7:0]  func;
      logic [15:0] addr;
      logic [15:0] word;

      // Mirror reset state: id 1, register 0 holds 250, empty frame.
      mirror_id  = mbrs_pkg::ID_RESET;
      mirror_crc = mbrs_pkg::CRC_INIT;
      mirror_len = 0;
      foreach (mirror_head[i]) mirror_head[i] = 8'h00;
      foreach (mirror_regs[i]) mirror_regs[i] = 16'h0000;
      mirror_regs[0] = mbrs_pkg::REG0_RESET;
      rand_bytes = 0;
      frame_no   = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed frames first.
      foreach (dir_rows[r]) begin
         if (dir_rows[r].set_id) begin
            set_slave_id(dir_rows[r].new_id);
         end
         send_frame(dir_rows[r].dst, dir_rows[r].func, dir_rows[r].addr, dir_rows[r].word,
                    dir_rows[r].len, dir_rows[r].crc_ok, dir_rows[r].end_mark,
                    dir_rows[r].kind);
      end

      // Random frames: mostly well-formed requests to this slave with random content,
      // the rest noise and frames whose end mark is missing, so they run into the next.
      while (rand_bytes < RANDOM_BYTES) begin
         // The id only changes between frames, never while one is still open.
         if (frame_no % 6 == 5 && mirror_len == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  set_slave_id(ID_MIN);
               end
               1: begin
                  set_slave_id(ID_MAX);
               end
               default: begin
                  set_slave_id(8'($urandom));
               end
            endcase
         end
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            dst  = ($urandom_range(0, 9) != 0) ? mirror_id : 8'($urandom);
            sel  = $urandom_range(0, 9);
            func = (sel < 5) ? mbrs_pkg::FN_READ :
                   (sel < 9) ? mbrs_pkg::FN_WRITE : 8'($urandom);
            addr = ($urandom_range(0, 7) != 0) ?
                   16'($urandom_range(0, mbrs_pkg::NUM_REGISTERS)) : 16'($urandom);
            if (func == mbrs_pkg::FN_READ && addr <= mbrs_pkg::NUM_REGISTERS &&
                $urandom_range(0, 7) != 0) begin
               word = 16'($urandom_range(0, mbrs_pkg::NUM_REGISTERS - addr));
            end else begin
               word = 16'($urandom);
            end
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : mbrs_pkg::HEAD_LEN;
            send_frame(dst, func, addr, word, len, $urandom_range(0, 9) != 0, 1'b1,
                       EXP_MODEL);
            rand_bytes += len;
         end else begin
            // Noise frames end normally; the broken kind leaves tlast low.
            send_frame(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                       $urandom_range(1, (pick < 9) ? 12 : 10), 1'($urandom_range(0, 1)),
                       pick < 9, EXP_MODEL);
         end
         // Now and then the sender holds off until the block has answered everything.
         if ($urandom_range(0, 7) == 0) begin
            wait_drained();
         end
         frame_no++;
      end

      // Close any frame left open by a missing end mark, then drain.
      send_frame(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 1, 1'b1, 1'b1,
                 EXP_MODEL);
      req_tvalid <= 1'b0;
      waited = 0;
      while (resp_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (resp_due.size() != 0) begin
         report_mismatch($sformatf("%0d expected response bytes never arrived",
                                   resp_due.size()));
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
